### sv/jdcd_pkg.sv
// ----------------------------------------------------------------------------
// jdcd_pkg
// shared widths, constants and the month start table for the julian day
// to calendar date converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jdcd_pkg;

    localparam int IN_W      = 39;
    localparam int OUT_FRAC_W = 16;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int YEAR_W    = 15;
    localparam int CE_W      = 9;
    localparam int G_W       = 4;
    localparam int GQ_W      = 5;
    localparam int NG_W      = 23;

    localparam longint unsigned GREG_LIMIT = 64'd2299160;
    localparam longint unsigned A_BIAS     = 64'd7468865;
    localparam longint unsigned A_DIV      = 64'd146097;
    localparam longint unsigned C_OFFSET   = 64'd1524;
    localparam longint unsigned D_MUL      = 64'd20;
    localparam longint unsigned D_BIAS     = 64'd2442;
    localparam longint unsigned D_DIV      = 64'd7305;
    localparam longint unsigned E_MUL      = 64'd1461;
    localparam longint unsigned G_MUL      = 64'd10000;
    localparam longint unsigned G_DIV      = 64'd306001;
    localparam longint unsigned YEAR_LATE  = 64'd4716;
    localparam longint unsigned YEAR_EARLY = 64'd4715;
    localparam int unsigned     G_WRAP     = 13;
    localparam int unsigned     MONTH_FEB  = 2;

    typedef logic [CE_W-1:0]       ce_t;
    typedef logic [G_W-1:0]        g_t;
    typedef logic [MONTH_W-1:0]    month_t;
    typedef logic [DAY_W-1:0]      day_t;
    typedef logic [OUT_FRAC_W-1:0] frac_t;
    typedef logic [YEAR_W-1:0]     year_t;

    // floor(30.6001 * g)
    function automatic ce_t month_start(input g_t g);
        ce_t s;
        unique case (g)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd30;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd91;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd183;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd244;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd336;
            4'd12:   s = 9'd367;
            4'd13:   s = 9'd397;
            4'd14:   s = 9'd428;
            4'd15:   s = 9'd459;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

### sv/jdcd_const_div.sv
// ----------------------------------------------------------------------------
// jdcd_const_div
// two stage unsigned division by a constant: reciprocal multiply estimate,
// then one multiply back, compare and correct
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdcd_const_div #(
    parameter int              NW  = 24,
    parameter longint unsigned DIV = 64'd7305,
    parameter int              QW  = 12
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    output logic [QW-1:0] quot
);

    localparam longint unsigned RECIP = (64'd1 << NW) / DIV;
    localparam int MW = $clog2(RECIP + 64'd1);
    localparam int PW = NW + MW;

    logic [PW-1:0] prod;
    logic [QW-1:0] est_next;
    logic [NW-1:0] num_reg;
    logic [QW-1:0] est_reg;
    logic [NW-1:0] back;
    logic [NW-1:0] rem;
    logic [QW-1:0] quot_next;
    logic [QW-1:0] quot_reg;

    assign prod     = PW'(num) * PW'(RECIP);
    assign est_next = QW'(prod >> NW);

    // estimate is low by at most one
    assign back      = NW'(est_reg) * NW'(DIV);
    assign rem       = num_reg - back;
    assign quot_next = (rem >= NW'(DIV)) ? est_reg + QW'(1) : est_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num;
            est_reg  <= est_next;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

### sv/julian_day_to_calendar_date.sv
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date
// throughput: one beat per cycle, limited by nothing but output stall
// a stall at the output freezes every stage at once, input stall follows it
// reset clears the stage valid bits only; no stored state otherwise
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module julian_day_to_calendar_date #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              date_valid,
    output logic                              date_stall,
    input  logic [jdcd_pkg::IN_W-1:0]         julian_date_fixed,
    output logic                              cal_valid,
    input  logic                              cal_stall,
    output logic [jdcd_pkg::MONTH_W-1:0]      month,
    output logic [jdcd_pkg::DAY_W-1:0]        day_of_month,
    output logic [jdcd_pkg::OUT_FRAC_W-1:0]   day_fraction,
    output logic signed [jdcd_pkg::YEAR_W-1:0] year
);

    import jdcd_pkg::*;

    localparam int LAT   = 12;
    localparam int SH_W  = IN_W + 1;
    localparam int ZW    = SH_W - FRAC_BITS;
    localparam int NAW   = ZW + 2;
    localparam int AW    = NAW - 17;
    localparam int CW    = ZW + 1;
    localparam int NDW   = CW + 5;
    localparam int DW    = NDW - 12;
    localparam int EW    = DW + 11;
    localparam int FR_DN = (FRAC_BITS >= OUT_FRAC_W) ? FRAC_BITS - OUT_FRAC_W : 0;
    localparam int FR_UP = (FRAC_BITS <  OUT_FRAC_W) ? OUT_FRAC_W - FRAC_BITS : 0;

    logic               en;
    logic [LAT-1:0]     vld_reg;
    logic [LAT-1:0]     vld_next;

    // stage 1
    logic [SH_W-1:0]    shifted;
    logic [ZW-1:0]      z_next;
    frac_t              frac_next;
    logic               greg_next;
    logic [NAW-1:0]     na_next;
    logic [ZW-1:0]      z1_reg, z2_reg, z3_reg;
    frac_t              frac1_reg, frac2_reg, frac3_reg, frac4_reg, frac5_reg, frac6_reg;
    frac_t              frac7_reg, frac8_reg, frac9_reg, frac10_reg, frac11_reg;
    logic               greg1_reg, greg2_reg, greg3_reg;
    logic [NAW-1:0]     na1_reg;

    // century correction
    logic [AW-1:0]      a3;
    logic [CW-1:0]      c_next;
    logic [CW-1:0]      c4_reg, c5_reg, c6_reg, c7_reg;
    logic [NDW-1:0]     nd_next;
    logic [NDW-1:0]     nd5_reg;

    // year count and day in year
    logic [DW-1:0]      d7;
    logic [EW-1:0]      e_prod;
    ce_t                ce_next;
    ce_t                ce8_reg, ce9_reg, ce10_reg, ce11_reg;
    logic [DW-1:0]      d8_reg, d9_reg, d10_reg, d11_reg;
    logic [NG_W-1:0]    ng_next;
    logic [NG_W-1:0]    ng9_reg;

    // month and output
    logic [GQ_W-1:0]    g11;
    g_t                 g;
    month_t             month_next;
    day_t               day_next;
    year_t              year_next;
    month_t             month_reg;
    day_t               day_reg;
    frac_t              frac_reg;
    year_t              year_reg;

    assign en         = !(vld_reg[LAT-1] && cal_stall);
    assign date_stall = !en;
    assign vld_next   = {vld_reg[LAT-2:0], date_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // round to day boundary at noon
    assign shifted   = SH_W'(julian_date_fixed) + (SH_W'(1) << (FRAC_BITS - 1));
    assign z_next    = shifted[SH_W-1:FRAC_BITS];
    assign frac_next = OUT_FRAC_W'((24'(shifted[FRAC_BITS-1:0]) << FR_UP) >> FR_DN);
    assign greg_next = 64'(z_next) > GREG_LIMIT;
    assign na_next   = {z_next, 2'b00} - NAW'(A_BIAS);

    jdcd_const_div #(
        .NW  (NAW),
        .DIV (A_DIV),
        .QW  (AW)
    ) u_div_a (
        .clk  (clk),
        .en   (en),
        .num  (na1_reg),
        .quot (a3)
    );

    assign c_next  = (greg3_reg ? CW'(z3_reg) + CW'(1) + CW'(a3) - CW'(a3 >> 2)
                                : CW'(z3_reg)) + CW'(C_OFFSET);
    assign nd_next = NDW'(c4_reg) * NDW'(D_MUL) - NDW'(D_BIAS);

    jdcd_const_div #(
        .NW  (NDW),
        .DIV (D_DIV),
        .QW  (DW)
    ) u_div_d (
        .clk  (clk),
        .en   (en),
        .num  (nd5_reg),
        .quot (d7)
    );

    assign e_prod  = EW'(d7) * EW'(E_MUL);
    assign ce_next = CE_W'(c7_reg - CW'(e_prod >> 2));
    assign ng_next = NG_W'(ce8_reg) * NG_W'(G_MUL);

    jdcd_const_div #(
        .NW  (NG_W),
        .DIV (G_DIV),
        .QW  (GQ_W)
    ) u_div_g (
        .clk  (clk),
        .en   (en),
        .num  (ng9_reg),
        .quot (g11)
    );

    assign g          = G_W'(g11);
    assign day_next   = DAY_W'(ce11_reg - month_start(g));
    assign month_next = (g <= G_W'(G_WRAP)) ? g - G_W'(1) : g - G_W'(G_WRAP);
    assign year_next  = YEAR_W'(64'(d11_reg)
                        - ((month_next > MONTH_W'(MONTH_FEB)) ? YEAR_LATE : YEAR_EARLY));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z1_reg     <= z_next;
            frac1_reg  <= frac_next;
            greg1_reg  <= greg_next;
            na1_reg    <= na_next;

            z2_reg     <= z1_reg;
            z3_reg     <= z2_reg;
            greg2_reg  <= greg1_reg;
            greg3_reg  <= greg2_reg;
            frac2_reg  <= frac1_reg;
            frac3_reg  <= frac2_reg;

            c4_reg     <= c_next;
            frac4_reg  <= frac3_reg;

            nd5_reg    <= nd_next;
            c5_reg     <= c4_reg;
            frac5_reg  <= frac4_reg;

            c6_reg     <= c5_reg;
            c7_reg     <= c6_reg;
            frac6_reg  <= frac5_reg;
            frac7_reg  <= frac6_reg;

            ce8_reg    <= ce_next;
            d8_reg     <= d7;
            frac8_reg  <= frac7_reg;

            ng9_reg    <= ng_next;
            ce9_reg    <= ce8_reg;
            d9_reg     <= d8_reg;
            frac9_reg  <= frac8_reg;

            ce10_reg   <= ce9_reg;
            ce11_reg   <= ce10_reg;
            d10_reg    <= d9_reg;
            d11_reg    <= d10_reg;
            frac10_reg <= frac9_reg;
            frac11_reg <= frac10_reg;

            month_reg  <= month_next;
            day_reg    <= day_next;
            frac_reg   <= frac11_reg;
            year_reg   <= year_next;
        end
    end

    assign cal_valid    = vld_reg[LAT-1];
    assign month        = month_reg;
    assign day_of_month = day_reg;
    assign day_fraction = frac_reg;
    assign year         = signed'(year_reg);

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the julian day to calendar date converter: a table of directed
// dates, some with typed expected values, then random dates, the rest checked against an integer calendar
// predictor, with random idling on both channels and a long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import jdcd_pkg::*;

    localparam int FRAC_BITS       = 16;
    localparam int RANDOM_ITEMS    = 400;
    localparam int QUIET_ITEMS     = 60;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 30;
    localparam int CYCLE_LIMIT     = 200000;
    localparam longint unsigned LAST_DAY = 64'd5373486;

    typedef logic [IN_W-1:0] jd_t;

    typedef struct {
        month_t month;
        day_t   day;
        frac_t  frac;
        year_t  year;
    } cal_date_t;

    typedef struct {
        jd_t       jd;
        bit        typed;
        cal_date_t date;
    } date_row_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   date_valid;
    logic   date_stall;
    jd_t    julian_date_fixed;
    logic   cal_valid;
    logic   cal_stall;
    month_t month;
    day_t   day_of_month;
    frac_t  day_fraction;
    logic signed [YEAR_W-1:0] year;

    date_row_t directed_rows[$];
    date_row_t expected_dates[$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        tail_quiet = 1'b0;
    bit        hold_off_req = 1'b0;

    julian_day_to_calendar_date #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .date_valid(date_valid),
        .date_stall(date_stall),
        .julian_date_fixed(julian_date_fixed),
        .cal_valid(cal_valid),
        .cal_stall(cal_stall),
        .month(month),
        .day_of_month(day_of_month),
        .day_fraction(day_fraction),
        .year(year)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // meeus method in exact integers
    function automatic cal_date_t calendar_of(input jd_t jd);
        longint unsigned shifted, z, frac, a, b, c, d, e, ce, g, mon, dom, offs;
        cal_date_t r;
        shifted = jd;
        shifted = shifted + (64'd1 << (FRAC_BITS - 1));
        z = shifted >> FRAC_BITS;
        frac = shifted & ((64'd1 << FRAC_BITS) - 1);
        if (z > GREG_LIMIT)
        begin
            a = (4 * z - A_BIAS) / A_DIV;
            b = z + 1 + a - a / 4;
        end
        else
        begin
            b = z;
        end
        c = b + C_OFFSET;
        d = (D_MUL * c - D_BIAS) / D_DIV;
        e = (E_MUL * d) >> 2;
        ce = c - e;
        g = (G_MUL * ce) / G_DIV;
        dom = ce - (G_DIV * g) / G_MUL;
        mon = (g <= G_WRAP) ? g - 1 : g - G_WRAP;
        offs = (mon > MONTH_FEB) ? YEAR_LATE : YEAR_EARLY;
        r.month = month_t'(mon);
        r.day = day_t'(dom);
        if (FRAC_BITS >= OUT_FRAC_W)
            r.frac = frac_t'(frac >> (FRAC_BITS - OUT_FRAC_W));
        else
            r.frac = frac_t'(frac << (OUT_FRAC_W - FRAC_BITS));
        r.year = year_t'(d - offs);
        return r;
    endfunction

    task automatic add_row(input jd_t jd, input bit typed, input int mon, input int dom,
                           input int frac, input int yr);
        date_row_t row;
        row.jd = jd;
        row.typed = typed;
        row.date.month = month_t'(mon);
        row.date.day = day_t'(dom);
        row.date.frac = frac_t'(frac);
        row.date.year = year_t'(yr);
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want, input jd_t jd);
        error_count++;
        $display("mismatch %s: got %0h want %0h for date %0h at cycle %0d",
                 what, got, want, jd, cycle_count);
    endtask

    task automatic offer_date(input date_row_t row);
        int gap;
        date_row_t pending;
        if (!tail_quiet && !hold_off_req && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            date_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        date_valid <= 1'b1;
        julian_date_fixed <= row.jd;
        do @(posedge clk); while (date_stall);
        pending.jd = row.jd;
        pending.typed = row.typed;
        pending.date = row.typed ? row.date : calendar_of(row.jd);
        expected_dates.push_back(pending);
    endtask

    // output side: random stall bursts, one long hold-off, quiet tail
    initial
    begin
        int n;
        cal_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                cal_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                cal_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else if (!tail_quiet && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 17);
                cal_stall <= 1'b1;
                repeat (n) @(negedge clk);
                cal_stall <= 1'b0;
            end
            else
            begin
                cal_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        date_row_t want;
        if (rst_n && cal_valid && !cal_stall)
        begin
            if (expected_dates.size() == 0)
            begin
                report_mismatch("unexpected beat", month, 0, '0);
            end
            else
            begin
                want = expected_dates.pop_front();
                if (month !== want.date.month)
                    report_mismatch("month", month, want.date.month, want.jd);
                if (day_of_month !== want.date.day)
                    report_mismatch("day_of_month", day_of_month, want.date.day, want.jd);
                if (day_fraction !== want.date.frac)
                    report_mismatch("day_fraction", day_fraction, want.date.frac, want.jd);
                if (year_t'(year) !== want.date.year)
                    report_mismatch("year", year_t'(year), want.date.year, want.jd);
            end
        end
    end

    initial
    begin
        date_row_t row;
        longint unsigned z;
        int idx;
        int pick;
        rst_n = 1'b0;
        date_valid = 1'b0;
        julian_date_fixed = '0;

        // noon, jan 1 -4712
        add_row(jd_t'(0), 1'b1, 1, 1, 16'h8000, -4712);
        add_row(jd_t'(32767), 1'b1, 1, 1, 16'hFFFF, -4712);
        add_row(jd_t'(32768), 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(1), 1'b0, 0, 0, 0, 0);
        // j2000
        add_row(jd_t'(64'd2451545 << FRAC_BITS), 1'b1, 1, 1, 16'h8000, 2000);
        // last julian day and first gregorian day
        add_row(jd_t'((64'd2299160 << FRAC_BITS) - 32768), 1'b1, 10, 4, 0, 1582);
        add_row(jd_t'((64'd2299161 << FRAC_BITS) - 32769), 1'b1, 10, 4, 16'hFFFF, 1582);
        add_row(jd_t'((64'd2299161 << FRAC_BITS) - 32768), 1'b1, 10, 15, 0, 1582);
        add_row(jd_t'((64'd2299162 << FRAC_BITS) - 32768), 1'b0, 0, 0, 0, 0);
        // leap days and year turns
        add_row(jd_t'(64'd2451604 << FRAC_BITS), 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(64'd2451605 << FRAC_BITS), 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(64'd2451544 << FRAC_BITS), 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(64'd2268992 << FRAC_BITS), 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(64'd1721058 << FRAC_BITS), 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(64'd1721057 << FRAC_BITS), 1'b0, 0, 0, 0, 0);
        // top of range, above range with year wrap, all ones
        add_row(jd_t'(64'd352156893184), 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(64'd352156893184 + 65535), 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(64'd6000000 << FRAC_BITS), 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(64'd8388607 << FRAC_BITS), 1'b0, 0, 0, 0, 0);
        add_row({IN_W{1'b1}}, 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(64'h5555555555), 1'b0, 0, 0, 0, 0);
        add_row(jd_t'(64'h2AAAAAAAAA), 1'b0, 0, 0, 0, 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            offer_date(directed_rows[i]);

        row.typed = 1'b0;
        row.date = '{default: '0};
        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            if (idx == RANDOM_ITEMS / 2)
                hold_off_req = 1'b1;
            if (idx == RANDOM_ITEMS - QUIET_ITEMS)
                tail_quiet = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick <= 4)
            begin
                z = $urandom_range(0, int'(LAST_DAY));
                row.jd = jd_t'((z << FRAC_BITS) | $urandom_range(0, 65535));
            end
            else if (pick <= 6)
            begin
                if (pick == 5)
                    z = GREG_LIMIT + $urandom_range(0, 40) - 20;
                else
                    z = $urandom_range(0, int'(LAST_DAY));
                case ($urandom_range(0, 2))
                    0: row.jd = jd_t'((z << FRAC_BITS) | 64'h7FFF);
                    1: row.jd = jd_t'((z << FRAC_BITS) | 64'h8000);
                    default: row.jd = jd_t'((z << FRAC_BITS) | $urandom_range(0, 65535));
                endcase
            end
            else if (pick <= 8)
            begin
                row.jd = {7'($urandom_range(0, 127)), 32'($urandom())};
            end
            else
            begin
                z = $urandom_range(2400000, 2500000);
                row.jd = jd_t'((z << FRAC_BITS) | $urandom_range(0, 65535));
            end
            offer_date(row);
        end
        @(negedge clk);
        date_valid <= 1'b0;

        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_dates.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
